[rtl/core/sbcf_pkg.sv]
// shared types, constants and coefficient table of the biquad cascade filter
package sbcf_pkg;

  // sizes
  localparam int SAMPLE_BITS   = 16;
  localparam int SECTION_COUNT = 4;
  localparam int TABLE_SECTIONS = 4;
  localparam int STATE_BITS    = 48;
  localparam int FRAC_BITS     = 24;
  localparam int COEF_BITS     = 32;
  localparam int COEF_FRAC     = 29;
  localparam int WIDE_W        = 56;
  localparam int SEC_W         = (SECTION_COUNT > 1) ? $clog2(SECTION_COUNT) : 1;
  localparam int OP_W          = 3;
  localparam int MEM_W         = 2 * STATE_BITS;

  // product codes of one section, in issue order
  localparam logic [OP_W-1:0] OP_B0X = 3'd0;
  localparam logic [OP_W-1:0] OP_B1X = 3'd1;
  localparam logic [OP_W-1:0] OP_B2X = 3'd2;
  localparam logic [OP_W-1:0] OP_A1Y = 3'd3;
  localparam logic [OP_W-1:0] OP_A2Y = 3'd4;

  localparam logic [SEC_W-1:0] LAST_SEC = SEC_W'(SECTION_COUNT - 1);

  // b0, b1, b2, a1, a2 per section in signed q2.29
  localparam logic signed [COEF_BITS-1:0] COEF_TABLE [TABLE_SECTIONS][5] = '{
    '{32'sd5281758, 32'sd10563515, 32'sd5281758, -32'sd468044480, 32'sd116742381},
    '{32'sd536870912, 32'sd1073741824, 32'sd536870912, -32'sd601380408, 32'sd311822088},
    '{32'sd536870912, -32'sd1073741824, 32'sd536870912, -32'sd1064984047, 32'sd528155194},
    '{32'sd536870912, -32'sd1073741824, 32'sd536870912, -32'sd1070180604, 32'sd533350687}
  };

  // saturation bounds of a state word, in the wide sum format
  localparam logic signed [WIDE_W-1:0] ST_MAX =
    {{(WIDE_W-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] ST_MIN = ~ST_MAX;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          window_start;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          clipped;
  } out_word_t;

  // control tag that follows one product down the datapath
  typedef struct packed {
    logic             act;
    logic             last;
    logic [SEC_W-1:0] sec;
    logic [OP_W-1:0]  op;
  } tag_t;

  function automatic logic signed [COEF_BITS-1:0] coef_sel(input logic [SEC_W-1:0] sec,
                                                          input logic [OP_W-1:0] op);
    logic signed [COEF_BITS-1:0] c;
    case (op)
      OP_B0X:  c = COEF_TABLE[sec][0];
      OP_B1X:  c = COEF_TABLE[sec][1];
      OP_B2X:  c = COEF_TABLE[sec][2];
      OP_A1Y:  c = COEF_TABLE[sec][3];
      OP_A2Y:  c = COEF_TABLE[sec][4];
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [STATE_BITS-1:0] sat_state(
      input logic signed [WIDE_W-1:0] v);
    logic signed [STATE_BITS-1:0] r;
    if (v > ST_MAX) begin
      r = ST_MAX[STATE_BITS-1:0];
    end else if (v < ST_MIN) begin
      r = ST_MIN[STATE_BITS-1:0];
    end else begin
      r = v[STATE_BITS-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/sos_biquad_cascade_filter.sv]
// four-section biquad cascade with per-window offset, section state kept in one memory
// a new word is taken only once the previous word has finished, set by the single shared
//   coefficient multiplier pair that computes five products per section in turn
// reset clears control, offset and per-section valid bits; invalid entries read as zero state
// a waiting output word does not block input: the next word is taken while it waits
module sos_biquad_cascade_filter
  import sbcf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int PL_W   = COEF_BITS + FRAC_BITS + 1;
  localparam int PH_W   = COEF_BITS + STATE_BITS - FRAC_BITS;
  localparam int PROD_W = COEF_BITS + STATE_BITS + 2;
  localparam int RND_W  = PROD_W - COEF_FRAC;
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int OQ_W   = STATE_BITS + 1 - FRAC_BITS;
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [STATE_BITS:0] OUT_HALF = (STATE_BITS+1)'(1) << (FRAC_BITS - 1);
  localparam logic signed [OQ_W-1:0] OUT_MAX = OQ_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [OQ_W-1:0] OUT_MIN = -OUT_MAX - OQ_W'(1);

  // control
  logic                          busy_r;
  logic                          clr_r;
  logic signed [SAMPLE_BITS-1:0] off_r;
  logic signed [STATE_BITS-1:0]  x0_r;
  logic                          iss_act_r;
  logic [SEC_W-1:0]              iss_sec_r;
  logic [OP_W-1:0]               iss_op_r;
  tag_t                          iss_tag;
  tag_t                          mul_tag_r;
  tag_t                          rnd_tag_r;
  logic                          advance;
  logic                          in_accept;
  logic                          finish;

  // datapath
  logic signed [COEF_BITS-1:0]   coef;
  logic signed [STATE_BITS-1:0]  mul_opnd;
  logic signed [FRAC_BITS:0]     opnd_lo;
  logic signed [STATE_BITS-FRAC_BITS-1:0] opnd_hi;
  logic signed [PL_W-1:0]        pl_r;
  logic signed [PH_W-1:0]        ph_r;
  logic signed [PROD_W-1:0]      full_sum;
  logic signed [RND_W-1:0]       rnd_r;
  logic signed [RND_W-1:0]       acc1_r;
  logic signed [RND_W-1:0]       acc2_r;
  logic signed [STATE_BITS-1:0]  y_r;
  logic signed [STATE_BITS-1:0]  f_r;
  logic signed [STATE_BITS-1:0]  first_q;
  logic signed [STATE_BITS-1:0]  second_q;
  logic signed [WIDE_W-1:0]      y_sum;
  logic signed [WIDE_W-1:0]      f_sum;
  logic signed [WIDE_W-1:0]      s_sum;
  logic signed [STATE_BITS-1:0]  s_new;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [SAMPLE_BITS-1:0] off_use;
  logic signed [STATE_BITS:0]    o_sum;
  logic signed [OQ_W-1:0]        o_q;

  // state memory: {first_delay, second_delay} per section
  logic [MEM_W-1:0]              dmem [SECTION_COUNT];
  logic [MEM_W-1:0]              rd_r;
  logic                          rd_zero_r;
  logic [SECTION_COUNT-1:0]      sec_vld_r;
  logic                          mem_re;
  logic                          mem_we;

  // output register
  logic                          out_valid_r;
  out_word_t                     out_data_r;

  // handshake
  assign in_stall  = busy_r;
  assign in_accept = in_valid && !busy_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the whole datapath waits only when the finished word cannot leave
  assign finish  = rnd_tag_r.act && rnd_tag_r.last && (rnd_tag_r.op == OP_A2Y);
  assign advance = !(finish && out_valid_r && out_stall);

  // input offset removal and widening to q24
  assign off_use = in_data.window_start ? in_data.sample : off_r;
  assign diff    = DIFF_W'(in_data.sample) - DIFF_W'(off_use);

  // issue stage: operand and coefficient select
  assign iss_tag.act  = iss_act_r;
  assign iss_tag.last = (iss_sec_r == LAST_SEC);
  assign iss_tag.sec  = iss_sec_r;
  assign iss_tag.op   = iss_op_r;
  assign coef         = coef_sel(iss_sec_r, iss_op_r);

  always_comb begin
    if (iss_op_r inside {OP_A1Y, OP_A2Y}) begin
      mul_opnd = y_r;
    end else if (iss_sec_r == '0) begin
      mul_opnd = x0_r;
    end else begin
      mul_opnd = y_r;
    end
  end

  assign opnd_lo = $signed({1'b0, mul_opnd[FRAC_BITS-1:0]});
  assign opnd_hi = mul_opnd[STATE_BITS-1:FRAC_BITS];

  // issue sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      iss_act_r <= 1'b0;
      iss_sec_r <= '0;
      iss_op_r  <= OP_B0X;
      off_r     <= '0;
    end else if (in_accept) begin
      busy_r    <= 1'b1;
      iss_act_r <= 1'b1;
      iss_sec_r <= '0;
      iss_op_r  <= OP_B0X;
      off_r     <= off_use;
    end else if (advance) begin
      if (finish) begin
        busy_r <= 1'b0;
      end
      if (iss_act_r) begin
        if (iss_op_r == OP_A2Y) begin
          iss_op_r <= OP_B0X;
          if (iss_sec_r == LAST_SEC) begin
            iss_act_r <= 1'b0;
          end else begin
            iss_sec_r <= iss_sec_r + SEC_W'(1);
          end
        end else begin
          iss_op_r <= iss_op_r + OP_W'(1);
        end
      end
    end
  end

  // per-word payload latched at accept
  always_ff @(posedge clk) begin
    if (in_accept) begin
      clr_r <= in_data.window_start;
      x0_r  <= sat_state(WIDE_W'(diff) <<< FRAC_BITS);
    end
  end

  // tag pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_tag_r <= '0;
      rnd_tag_r <= '0;
    end else if (advance) begin
      mul_tag_r <= iss_tag;
      rnd_tag_r <= mul_tag_r;
    end
  end

  // multiply stage: 48-bit operand split into two 24-bit halves
  always_ff @(posedge clk) begin
    if (advance) begin
      pl_r <= coef * opnd_lo;
      ph_r <= coef * opnd_hi;
    end
  end

  // recombine halves and round to q24, half up
  assign full_sum = (PROD_W'(ph_r) <<< FRAC_BITS) + PROD_W'(pl_r) + RND_HALF;

  always_ff @(posedge clk) begin
    if (advance) begin
      rnd_r <= $signed(full_sum[PROD_W-1:COEF_FRAC]);
    end
  end

  // state memory read, masked to zero for a fresh window or a never written entry
  assign mem_re = advance && iss_act_r && (iss_op_r == OP_B0X);

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_r      <= dmem[iss_sec_r];
      rd_zero_r <= clr_r || !sec_vld_r[iss_sec_r];
    end
  end

  assign first_q  = rd_zero_r ? '0 : $signed(rd_r[MEM_W-1:STATE_BITS]);
  assign second_q = rd_zero_r ? '0 : $signed(rd_r[STATE_BITS-1:0]);

  // section update sums
  assign y_sum = WIDE_W'(rnd_r) + WIDE_W'(first_q);
  assign f_sum = WIDE_W'(acc1_r) - WIDE_W'(rnd_r) + WIDE_W'(second_q);
  assign s_sum = WIDE_W'(acc2_r) - WIDE_W'(rnd_r);
  assign s_new = sat_state(s_sum);

  // accumulate stage
  always_ff @(posedge clk) begin
    if (advance && rnd_tag_r.act) begin
      case (rnd_tag_r.op)
        OP_B0X:  y_r    <= sat_state(y_sum);
        OP_B1X:  acc1_r <= rnd_r;
        OP_B2X:  acc2_r <= rnd_r;
        OP_A1Y:  f_r    <= sat_state(f_sum);
        OP_A2Y:  ;
        default: ;
      endcase
    end
  end

  // state memory write back
  assign mem_we = advance && rnd_tag_r.act && (rnd_tag_r.op == OP_A2Y);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dmem[rnd_tag_r.sec] <= {f_r, s_new};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_vld_r <= '0;
    end else if (mem_we) begin
      sec_vld_r[rnd_tag_r.sec] <= 1'b1;
    end
  end

  // final rounding to integer and saturation
  assign o_sum = (STATE_BITS+1)'(y_r) + OUT_HALF;
  assign o_q   = o_sum[STATE_BITS:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish && advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish && advance) begin
      if (o_q > OUT_MAX) begin
        out_data_r.filtered <= OUT_MAX[SAMPLE_BITS-1:0];
        out_data_r.clipped  <= 1'b1;
      end else if (o_q < OUT_MIN) begin
        out_data_r.filtered <= OUT_MIN[SAMPLE_BITS-1:0];
        out_data_r.clipped  <= 1'b1;
      end else begin
        out_data_r.filtered <= o_q[SAMPLE_BITS-1:0];
        out_data_r.clipped  <= 1'b0;
      end
    end
  end

  // checks
  a_done_has_word: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> out_valid_r)
    else $error("cascade finished without presenting an output word");

  a_no_mem_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_re && mem_we) |-> (iss_sec_r != rnd_tag_r.sec))
    else $error("state memory read and write hit the same section");

  a_accept_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> (!iss_act_r && !mul_tag_r.act && !rnd_tag_r.act))
    else $error("input word taken while the datapath still holds work");

endmodule
